FILE: hdl/rsdec_pkg.sv
// ----------------------------------------------------------------------------
// rsdec_pkg
// gf(16) types, tables and arithmetic shared by the rs(15,11) decoder
// ----------------------------------------------------------------------------
package rsdec_pkg;

    localparam int SYMS   = 15;
    localparam int SYM_W  = 4;
    localparam int WORD_W = SYMS * SYM_W;

    typedef logic [SYM_W-1:0]  gf_t;
    typedef logic [WORD_W-1:0] word_t;

    // alpha^k, k = 0..14; the last entry wraps to alpha^15 = 1
    localparam gf_t GF_EXP [0:15] = '{
        4'd1, 4'd2, 4'd4, 4'd8, 4'd3, 4'd6, 4'd12, 4'd11,
        4'd5, 4'd10, 4'd7, 4'd14, 4'd15, 4'd13, 4'd9, 4'd1
    };

    // log_alpha(v); entry for zero is unused
    localparam gf_t GF_LOG [0:15] = '{
        4'd0, 4'd0, 4'd1, 4'd4, 4'd2, 4'd8, 4'd5, 4'd10,
        4'd3, 4'd14, 4'd9, 4'd7, 4'd6, 4'd13, 4'd11, 4'd12
    };

    function automatic gf_t gf_mul(input gf_t a, input gf_t b);
        logic [4:0] sum;
        gf_t        res;
        sum = {1'b0, GF_LOG[a]} + {1'b0, GF_LOG[b]};
        if (sum >= 5'(SYMS))
        begin
            sum = sum - 5'(SYMS);
        end
        if (a == '0 || b == '0)
        begin
            res = '0;
        end
        else
        begin
            res = GF_EXP[sum[3:0]];
        end
        return res;
    endfunction

    // division by zero gives zero
    function automatic gf_t gf_div(input gf_t a, input gf_t b);
        logic [4:0] diff;
        gf_t        res;
        diff = {1'b0, GF_LOG[a]} + 5'(SYMS) - {1'b0, GF_LOG[b]};
        if (diff >= 5'(SYMS))
        begin
            diff = diff - 5'(SYMS);
        end
        if (a == '0 || b == '0)
        begin
            res = '0;
        end
        else
        begin
            res = GF_EXP[diff[3:0]];
        end
        return res;
    endfunction

endpackage

FILE: hdl/rs_15_11_gf16_decoder_top.sv
// ----------------------------------------------------------------------------
// rs_15_11_gf16_decoder_top
// rs(15,11) decoder over gf(16): syndromes, peterson solve, parallel root
// search and correction of up to two symbols
// ----------------------------------------------------------------------------
// an accepted beat moves through the syndrome, key equation, root search,
// locator and correction stages in order; out_valid is the last stage's flag
// throughput: one codeword per cycle while out_stall is low
// each stage holds its beat while the next is full and stalled
// reset clears the stage valid flags only; payload registers are not reset
// ----------------------------------------------------------------------------
module rs_15_11_gf16_decoder_top
    import rsdec_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  word_t codeword,
    output logic  out_valid,
    input  logic  out_stall,
    output word_t corrected_word,
    output logic  error_found
);

    // stage valid flags and readiness
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5     = !v5_reg || !out_stall;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // stage 1: syndrome lanes
    gf_t   synd_next [4];
    gf_t   s_reg [4];
    word_t w1_reg;

    genvar i;
    generate
        for (i = 0; i < 4; i++)
        begin : g_synd
            rsdec_synd_lane #(.IDX(i + 1)) u_synd (
                .codeword (codeword),
                .syndrome (synd_next[i])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            w1_reg <= codeword;
            for (int k = 0; k < 4; k++)
            begin
                s_reg[k] <= synd_next[k];
            end
        end
    end

    // stage 2: key equation coefficients and single-error solve
    gf_t   d2_next, d1_next, d0_next;
    logic  single_next, two_next, any_next;
    gf_t   xs_next, es_next;

    gf_t   d2_reg, d1_reg, d0_reg, s1_2_reg, s2_2_reg, xs_2_reg, es_2_reg;
    logic  single_2_reg, two_2_reg, any_2_reg;
    word_t w2_reg;

    always_comb
    begin
        d2_next = gf_mul(s_reg[0], s_reg[2]) ^ gf_mul(s_reg[1], s_reg[1]);
        d1_next = gf_mul(s_reg[0], s_reg[3]) ^ gf_mul(s_reg[1], s_reg[2]);
        d0_next = gf_mul(s_reg[2], s_reg[2]) ^ gf_mul(s_reg[1], s_reg[3]);
        any_next = (s_reg[0] != '0) || (s_reg[1] != '0) ||
                   (s_reg[2] != '0) || (s_reg[3] != '0);
        single_next = (d2_next == '0) && (d1_next == '0) &&
                      (s_reg[0] != '0) && (s_reg[1] != '0) &&
                      (s_reg[2] != '0) && (s_reg[3] != '0);
        two_next = (d2_next != '0) && (d1_next != '0) && (d0_next != '0);
        xs_next  = gf_div(s_reg[1], s_reg[0]);
        es_next  = gf_div(gf_mul(s_reg[0], s_reg[0]), s_reg[1]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            d2_reg       <= d2_next;
            d1_reg       <= d1_next;
            d0_reg       <= d0_next;
            s1_2_reg     <= s_reg[0];
            s2_2_reg     <= s_reg[1];
            xs_2_reg     <= xs_next;
            es_2_reg     <= es_next;
            single_2_reg <= single_next;
            two_2_reg    <= two_next;
            any_2_reg    <= any_next;
            w2_reg       <= w1_reg;
        end
    end

    // stage 3: root search lanes and merge
    logic [SYMS-1:0] hits;
    logic            found_next;
    gf_t             x0_next;

    generate
        for (i = 0; i < SYMS; i++)
        begin : g_root
            rsdec_root_lane #(.POW(i)) u_root (
                .d2  (d2_reg),
                .d1  (d1_reg),
                .d0  (d0_reg),
                .hit (hits[i])
            );
        end
    endgenerate

    // lowest power wins
    always_comb
    begin
        found_next = 1'b0;
        x0_next    = '0;
        for (int k = SYMS - 1; k >= 0; k--)
        begin
            if (hits[k])
            begin
                found_next = 1'b1;
                x0_next    = GF_EXP[k];
            end
        end
    end

    gf_t   x0_3_reg, q_3_reg, s1_3_reg, s2_3_reg, xs_3_reg, es_3_reg;
    logic  two_3_reg, single_3_reg, any_3_reg;
    word_t w3_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            x0_3_reg     <= x0_next;
            q_3_reg      <= gf_div(d1_reg, d2_reg);
            s1_3_reg     <= s1_2_reg;
            s2_3_reg     <= s2_2_reg;
            xs_3_reg     <= xs_2_reg;
            es_3_reg     <= es_2_reg;
            two_3_reg    <= two_2_reg && found_next;
            single_3_reg <= single_2_reg;
            any_3_reg    <= any_2_reg;
            w3_reg       <= w2_reg;
        end
    end

    // stage 4: second locator, denominators and numerators
    gf_t  x1_next, den0_next, den1_next, x0x1;
    logic two_ok_next;

    always_comb
    begin
        x1_next     = q_3_reg ^ x0_3_reg;
        x0x1        = gf_mul(x0_3_reg, x1_next);
        den0_next   = x0x1 ^ gf_mul(x0_3_reg, x0_3_reg);
        den1_next   = x0x1 ^ gf_mul(x1_next, x1_next);
        two_ok_next = two_3_reg && (x1_next != '0) &&
                      (den0_next != '0) && (den1_next != '0);
    end

    gf_t   x0_4_reg, x1_4_reg, den0_4_reg, den1_4_reg, num0_4_reg, num1_4_reg;
    gf_t   xs_4_reg, es_4_reg;
    logic  two_4_reg, single_4_reg, any_4_reg;
    word_t w4_reg;

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            x0_4_reg     <= x0_3_reg;
            x1_4_reg     <= x1_next;
            den0_4_reg   <= den0_next;
            den1_4_reg   <= den1_next;
            num0_4_reg   <= gf_mul(s1_3_reg, x1_next) ^ s2_3_reg;
            num1_4_reg   <= gf_mul(s1_3_reg, x0_3_reg) ^ s2_3_reg;
            xs_4_reg     <= xs_3_reg;
            es_4_reg     <= es_3_reg;
            two_4_reg    <= two_ok_next;
            single_4_reg <= single_3_reg;
            any_4_reg    <= any_3_reg;
            w4_reg       <= w3_reg;
        end
    end

    // stage 5: error values and per-symbol correction
    gf_t   e0, e1, lg_x0, lg_x1, lg_xs;
    word_t fixed_next;

    always_comb
    begin
        e0         = gf_div(num0_4_reg, den0_4_reg);
        e1         = gf_div(num1_4_reg, den1_4_reg);
        lg_x0      = GF_LOG[x0_4_reg];
        lg_x1      = GF_LOG[x1_4_reg];
        lg_xs      = GF_LOG[xs_4_reg];
        fixed_next = w4_reg;
        for (int k = 0; k < SYMS; k++)
        begin
            if (single_4_reg && lg_xs == 4'(SYMS - 1 - k))
            begin
                fixed_next[k*SYM_W +: SYM_W] = fixed_next[k*SYM_W +: SYM_W] ^ es_4_reg;
            end
            if (two_4_reg && lg_x0 == 4'(SYMS - 1 - k))
            begin
                fixed_next[k*SYM_W +: SYM_W] = fixed_next[k*SYM_W +: SYM_W] ^ e0;
            end
            if (two_4_reg && lg_x1 == 4'(SYMS - 1 - k))
            begin
                fixed_next[k*SYM_W +: SYM_W] = fixed_next[k*SYM_W +: SYM_W] ^ e1;
            end
        end
    end

    word_t out_word_reg, raw_word_reg;
    logic  err_reg;

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            out_word_reg <= fixed_next;
            raw_word_reg <= w4_reg;
            err_reg      <= any_4_reg;
        end
    end

    assign out_valid      = v5_reg;
    assign corrected_word = out_word_reg;
    assign error_found    = err_reg;

`ifndef NO_ASSERTIONS
    // a clean word must pass through untouched
    a_clean_passes: assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && !err_reg) |-> (out_word_reg == raw_word_reg))
        else $error("clean codeword was altered");

    // single and double correction are exclusive
    a_one_mode: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> !(single_4_reg && two_4_reg))
        else $error("single and double correction both selected");

    // an accepted beat enters the first stage
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v1_reg)
        else $error("accepted beat lost at stage one");

    // a stalled result stays in the output stage
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && out_stall) |=> (v5_reg && $stable(out_word_reg)))
        else $error("stalled result dropped");
`endif

endmodule

FILE: hdl/rsdec_synd_lane.sv
// ----------------------------------------------------------------------------
// rsdec_synd_lane
// one syndrome lane: evaluates the received word at alpha^IDX
// ----------------------------------------------------------------------------
module rsdec_synd_lane
    import rsdec_pkg::*;
#(
    parameter int IDX = 1
)
(
    input  word_t codeword,
    output gf_t   syndrome
);

    gf_t terms [SYMS];

    genvar j;
    generate
        for (j = 0; j < SYMS; j++)
        begin : g_term
            // symbol j is the coefficient of x^(14-j)
            localparam int EXPO = (IDX * (SYMS - 1 - j)) % SYMS;
            assign terms[j] = gf_mul(codeword[j*SYM_W +: SYM_W], GF_EXP[EXPO]);
        end
    endgenerate

    always_comb
    begin
        syndrome = '0;
        for (int k = 0; k < SYMS; k++)
        begin
            syndrome = syndrome ^ terms[k];
        end
    end

endmodule

FILE: hdl/rsdec_root_lane.sv
// ----------------------------------------------------------------------------
// rsdec_root_lane
// one root search lane: tests alpha^POW against d2*x^2 + d1*x + d0
// ----------------------------------------------------------------------------
module rsdec_root_lane
    import rsdec_pkg::*;
#(
    parameter int POW = 0
)
(
    input  gf_t  d2,
    input  gf_t  d1,
    input  gf_t  d0,
    output logic hit
);

    localparam int POW_SQ = (2 * POW) % SYMS;

    gf_t val;

    assign val = gf_mul(d2, GF_EXP[POW_SQ]) ^ gf_mul(d1, GF_EXP[POW]) ^ d0;
    assign hit = (val == '0);

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the rs(15,11) gf(16) decoder: codewords built by a
// polynomial encoder with injected symbol errors, plus raw noise, are sent
// through the valid/stall handshake under several idle and stall mixes; every
// output beat is compared with a local syndrome and peterson-solve predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import rsdec_pkg::*;

    typedef enum int
    {
        DEC_CLEAN,
        DEC_SINGLE,
        DEC_SINGLE_DEGEN,
        DEC_DOUBLE,
        DEC_DOUBLE_DEGEN,
        DEC_NO_ROOT
    } dec_case_t;

    typedef struct packed
    {
        word_t word;
        logic  flag;
    } decoded_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_stall;
    word_t codeword = '0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    word_t corrected_word;
    logic  error_found;

    decoded_t pending_q[$];
    int       fail_count = 0;
    int       tx_idle_pct = 0;
    int       rx_stall_pct = 0;
    int       hold_left = 0;

    rs_15_11_gf16_decoder_top dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .codeword       (codeword),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .corrected_word (corrected_word),
        .error_found    (error_found)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // gf(16) arithmetic, x^4 + x + 1
    function automatic gf_t gf_times(input gf_t a, input gf_t b);
        logic [6:0] prod;
        prod = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (b[i])
            begin
                prod = prod ^ (7'(a) << i);
            end
        end
        for (int k = 6; k >= 4; k--)
        begin
            if (prod[k])
            begin
                prod = prod ^ (7'b0010011 << (k - 4));
            end
        end
        return prod[3:0];
    endfunction

    function automatic gf_t alpha_pow(input int n);
        gf_t r;
        r = 4'd1;
        for (int k = 0; k < n % 15; k++)
        begin
            r = gf_times(r, 4'd2);
        end
        return r;
    endfunction

    function automatic gf_t gf_over(input gf_t a, input gf_t b);
        gf_t inv;
        if (b == '0)
        begin
            return '0;
        end
        inv = 4'd1;
        repeat (14)
        begin
            inv = gf_times(inv, b);
        end
        return gf_times(a, inv);
    endfunction

    function automatic word_t flip_symbol(input word_t w, input gf_t loc, input gf_t ev);
        int p;
        p = 0;
        for (int k = 0; k < 15; k++)
        begin
            if (alpha_pow(k) == loc)
            begin
                p = k;
            end
        end
        return w ^ (word_t'(ev) << (4 * (14 - p)));
    endfunction

    function automatic void decode_word(input word_t rx, output word_t fixed,
                                        output logic flag, output dec_case_t kind);
        gf_t  synd [1:4];
        gf_t  step, acc, d2, d1, d0, a, x0, x1, den0, den1, e0, e1;
        logic found;
        fixed = rx;
        flag = 1'b0;
        for (int i = 1; i <= 4; i++)
        begin
            step = alpha_pow(i);
            acc = '0;
            for (int j = 0; j < 15; j++)
            begin
                acc = gf_times(acc, step) ^ rx[4*j +: 4];
            end
            synd[i] = acc;
            if (acc != '0)
            begin
                flag = 1'b1;
            end
        end
        d2 = gf_times(synd[1], synd[3]) ^ gf_times(synd[2], synd[2]);
        d1 = gf_times(synd[1], synd[4]) ^ gf_times(synd[2], synd[3]);
        d0 = gf_times(synd[3], synd[3]) ^ gf_times(synd[2], synd[4]);
        if (!flag)
        begin
            kind = DEC_CLEAN;
        end
        else if (d2 == '0)
        begin
            if (d1 == '0 && synd[1] != '0 && synd[2] != '0 && synd[3] != '0
                && synd[4] != '0)
            begin
                fixed = flip_symbol(fixed, gf_over(synd[2], synd[1]),
                                    gf_over(gf_times(synd[1], synd[1]), synd[2]));
                kind = DEC_SINGLE;
            end
            else
            begin
                kind = DEC_SINGLE_DEGEN;
            end
        end
        else if (d1 == '0 || d0 == '0)
        begin
            kind = DEC_DOUBLE_DEGEN;
        end
        else
        begin
            found = 1'b0;
            x0 = '0;
            for (int i = 0; i < 15 && !found; i++)
            begin
                a = alpha_pow(i);
                if ((gf_times(d2, gf_times(a, a)) ^ gf_times(d1, a) ^ d0) == '0)
                begin
                    x0 = a;
                    found = 1'b1;
                end
            end
            if (!found)
            begin
                kind = DEC_NO_ROOT;
            end
            else
            begin
                x1 = gf_over(d1, d2) ^ x0;
                den0 = gf_times(x0, x1) ^ gf_times(x0, x0);
                den1 = gf_times(x0, x1) ^ gf_times(x1, x1);
                e0 = gf_over(gf_times(synd[1], x1) ^ synd[2], den0);
                e1 = gf_over(gf_times(synd[1], x0) ^ synd[2], den1);
                if (x1 != '0 && den0 != '0 && den1 != '0)
                begin
                    fixed = flip_symbol(flip_symbol(fixed, x0, e0), x1, e1);
                    kind = DEC_DOUBLE;
                end
                else
                begin
                    kind = DEC_DOUBLE_DEGEN;
                end
            end
        end
    endfunction

    // codeword = m(x) * g(x), g with roots alpha^1..alpha^4
    function automatic word_t encode_msg(input logic [43:0] msg);
        gf_t   gen [0:4];
        gf_t   coef [0:14];
        gf_t   root;
        word_t w;
        for (int d = 0; d <= 4; d++)
        begin
            gen[d] = (d == 0) ? 4'd1 : 4'd0;
        end
        for (int k = 1; k <= 4; k++)
        begin
            root = alpha_pow(k);
            for (int d = k; d >= 1; d--)
            begin
                gen[d] = gen[d-1] ^ gf_times(gen[d], root);
            end
            gen[0] = gf_times(gen[0], root);
        end
        for (int d = 0; d < 15; d++)
        begin
            coef[d] = '0;
        end
        for (int m = 0; m < 11; m++)
        begin
            for (int d = 0; d <= 4; d++)
            begin
                coef[m+d] = coef[m+d] ^ gf_times(msg[4*m +: 4], gen[d]);
            end
        end
        for (int j = 0; j < 15; j++)
        begin
            w[4*j +: 4] = coef[14-j];
        end
        return w;
    endfunction

    function automatic logic [43:0] random_msg();
        return 44'({$urandom(), $urandom()});
    endfunction

    function automatic word_t random_noise();
        return word_t'({$urandom(), $urandom()});
    endfunction

    function automatic word_t add_errors(input word_t w, input int n);
        logic [14:0] used;
        int          pos;
        used = '0;
        for (int e = 0; e < n; e++)
        begin
            do
            begin
                pos = $urandom_range(14);
            end
            while (used[pos]);
            used[pos] = 1'b1;
            w[4*pos +: 4] = w[4*pos +: 4] ^ 4'($urandom_range(15, 1));
        end
        return w;
    endfunction

    function automatic word_t random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            return random_noise();
        end
        else if (pick < 20)
        begin
            return encode_msg(random_msg());
        end
        else if (pick < 50)
        begin
            return add_errors(encode_msg(random_msg()), 1);
        end
        else if (pick < 85)
        begin
            return add_errors(encode_msg(random_msg()), 2);
        end
        return add_errors(encode_msg(random_msg()), $urandom_range(5, 3));
    endfunction

    task automatic send_word(input word_t w);
        word_t     fixed;
        logic      flag;
        dec_case_t kind;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        codeword <= w;
        @(posedge clk);
        while (in_stall !== 1'b0)
        begin
            @(posedge clk);
        end
        decode_word(w, fixed, flag, kind);
        pending_q.push_back('{word: fixed, flag: flag});
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // search random words until the local decoder model takes the wanted path, giving up after 100000 tries
    task automatic send_case(input dec_case_t want);
        word_t     cand;
        word_t     fixed;
        logic      flag;
        dec_case_t kind;
        int        tries;
        tries = 0;
        do
        begin
            if (tries % 2 == 1)
            begin
                cand = random_noise();
            end
            else
            begin
                cand = add_errors(encode_msg(random_msg()), 3);
            end
            decode_word(cand, fixed, flag, kind);
            tries++;
        end
        while (kind != want && tries < 100000);
        send_word(cand);
    endtask

    task automatic report_mismatch(input string what, input word_t want_v,
                                   input word_t got_v);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, what,
                     want_v, got_v);
        end
    endtask

    task automatic test_directed();
        word_t base;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        base = encode_msg(random_msg());
        send_word('0);
        send_word({WORD_W{1'b1}});
        send_word(encode_msg({44{1'b1}}));
        send_word(base);
        send_word(base ^ (word_t'(4'hf) << 0));
        send_word(base ^ (word_t'(4'h1) << 56));
        send_word(base ^ (word_t'(4'h8) << 28));
        send_word(base ^ (word_t'(4'h1) << 0) ^ (word_t'(4'hf) << 56));
        send_word(base ^ (word_t'(4'h3) << 4) ^ (word_t'(4'h3) << 8));
        send_word(add_errors(base, 3));
        send_word(add_errors(base, 5));
        send_case(DEC_SINGLE_DEGEN);
        send_case(DEC_SINGLE_DEGEN);
        send_case(DEC_DOUBLE_DEGEN);
        send_case(DEC_DOUBLE_DEGEN);
        send_case(DEC_NO_ROOT);
        send_case(DEC_NO_ROOT);
        send_case(DEC_DOUBLE);
        send_case(DEC_SINGLE);
    endtask

    task automatic test_random(input int count, input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (count)
        begin
            send_word(random_item());
        end
    endtask

    // long output hold while input keeps coming, then a full drain
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_left = 80;
        repeat (40)
        begin
            send_word(random_item());
        end
        wait_drained();
    endtask

    // receiver
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    // output checker
    initial
    begin
        decoded_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (pending_q.size() == 0)
                begin
                    report_mismatch("unpredicted beat, word", '0, corrected_word);
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (corrected_word !== want.word)
                    begin
                        report_mismatch("corrected_word", want.word, corrected_word);
                    end
                    if (error_found !== want.flag)
                    begin
                        report_mismatch("error_found", word_t'(want.flag),
                                        word_t'(error_found));
                    end
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        wait_drained();
        test_random(450, 0, 0);
        wait_drained();
        test_backpressure();
        test_random(450, 46, 0);
        wait_drained();
        test_random(450, 0, 46);
        wait_drained();
        test_random(450, 36, 36);
        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_q.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/rsdec_pkg.sv
hdl/rsdec_synd_lane.sv
hdl/rsdec_root_lane.sv
hdl/rs_15_11_gf16_decoder_top.sv
tb/tb_top.sv
